// ===== hw/rtl/idalloc_pkg.sv =====
package idalloc_pkg;

  // identifier width as stored in the free list
  localparam int ID_W = 8;

  // operation codes
  localparam logic [2:0] OP_ALLOCATE = 3'd0;
  localparam logic [2:0] OP_RELEASE  = 3'd1;
  localparam logic [2:0] OP_CLAIM    = 3'd2;
  localparam logic [2:0] OP_PROBE    = 3'd3;
  localparam logic [2:0] OP_CLEAR    = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // one result transfer towards the output stage
  typedef struct packed {
    logic [ID_W-1:0] result_id;
    logic [1:0]      status;
    logic [8:0]      free_count;
    logic [8:0]      high_water;
  } result_t;

endpackage

// ===== hw/rtl/idalloc_ram.sv =====
module idalloc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/idalloc_ctrl.sv =====
module idalloc_ctrl #(
  parameter int MAX_IDS = 256,
  localparam int AW = $clog2(MAX_IDS),
  localparam int CW = $clog2(MAX_IDS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  in_operation,
  input  logic [idalloc_pkg::ID_W-1:0] in_target_id,
  output logic                        res_valid,
  input  logic                        res_ready,
  output idalloc_pkg::result_t        res,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [idalloc_pkg::ID_W-1:0] ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [idalloc_pkg::ID_W-1:0] ram_rdata
);

  localparam int CMPW = (CW > idalloc_pkg::ID_W) ? CW : idalloc_pkg::ID_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_COMPACT,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [AW-1:0]               head_r;
  logic [AW-1:0]               tail_r;
  logic [AW-1:0]               rd_ptr_r;
  logic [AW-1:0]               wr_ptr_r;
  logic [AW-1:0]               chk_addr_r;
  logic [CW-1:0]               count_r;
  logic [CW-1:0]               fresh_r;
  logic [CW-1:0]               rd_idx_r;
  logic [CW-1:0]               chk_idx_r;
  logic [CW-1:0]               mv_left_r;
  logic                        chk_v_r;
  logic                        mv_v_r;
  logic                        is_claim_r;
  logic [idalloc_pkg::ID_W-1:0] tgt_r;
  logic [idalloc_pkg::ID_W-1:0] res_id_r;
  logic [1:0]                  res_status_r;

  logic                        accept;
  logic                        hit;
  logic [CMPW-1:0]             tgt_ext;
  logic [CMPW-1:0]             tgt_inc;
  logic [CMPW-1:0]             fresh_ext;
  logic                        rel_reject;
  logic                        rel_top;
  logic                        list_full;
  logic                        rel_append;
  logic [AW:0]                 ring_sum;
  logic [AW-1:0]               ring_tail;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    ptr_inc = (p == AW'(MAX_IDS - 1)) ? '0 : p + 1'b1;
  endfunction

  // nothing is taken while reset is held
  assign in_stall = !rst_n || (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign hit      = chk_v_r && (ram_rdata == tgt_r);

  assign tgt_ext    = CMPW'(in_target_id);
  assign tgt_inc    = tgt_ext + 1'b1;
  assign fresh_ext  = CMPW'(fresh_r);
  assign rel_reject = (tgt_ext >= fresh_ext);
  assign rel_top    = (tgt_inc == fresh_ext);
  assign list_full  = (count_r == CW'(MAX_IDS));
  assign rel_append = !rel_reject && !rel_top && !list_full;

  // memory port steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = in_target_id;
    ram_raddr = head_r;
    case (state_r)
      S_IDLE: begin
        ram_we = accept && (in_operation == idalloc_pkg::OP_RELEASE) && rel_append;
      end
      S_SCAN: begin
        ram_raddr = rd_ptr_r;
      end
      S_COMPACT: begin
        ram_raddr = rd_ptr_r;
        ram_we    = mv_v_r;
        ram_waddr = wr_ptr_r;
        ram_wdata = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      fresh_r <= '0;
      chk_v_r <= 1'b0;
      mv_v_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            tgt_r        <= in_target_id;
            is_claim_r   <= (in_operation == idalloc_pkg::OP_CLAIM);
            res_id_r     <= in_target_id;
            res_status_r <= idalloc_pkg::ST_MISS;
            state_r      <= S_DONE;
            unique case (in_operation) inside
              idalloc_pkg::OP_ALLOCATE: begin
                res_id_r <= '0;
                if (count_r != '0) begin
                  state_r <= S_ALLOC;
                end else if (fresh_r != CW'(MAX_IDS)) begin
                  res_id_r     <= idalloc_pkg::ID_W'(fresh_r);
                  fresh_r      <= fresh_r + 1'b1;
                  res_status_r <= idalloc_pkg::ST_OK;
                end
              end
              idalloc_pkg::OP_RELEASE: begin
                if (!rel_reject) begin
                  if (rel_top) begin
                    fresh_r      <= fresh_r - 1'b1;
                    res_status_r <= idalloc_pkg::ST_OK;
                  end else if (list_full) begin
                    res_status_r <= idalloc_pkg::ST_FULL;
                  end else begin
                    tail_r       <= ptr_inc(tail_r);
                    count_r      <= count_r + 1'b1;
                    res_status_r <= idalloc_pkg::ST_OK;
                  end
                end
              end
              idalloc_pkg::OP_CLAIM, idalloc_pkg::OP_PROBE: begin
                state_r  <= S_SCAN;
                rd_ptr_r <= head_r;
                rd_idx_r <= '0;
                chk_v_r  <= 1'b0;
              end
              idalloc_pkg::OP_CLEAR: begin
                head_r       <= '0;
                tail_r       <= '0;
                count_r      <= '0;
                fresh_r      <= '0;
                res_status_r <= idalloc_pkg::ST_OK;
              end
              default: ;
            endcase
          end
        end
        S_ALLOC: begin
          res_id_r     <= ram_rdata;
          res_status_r <= idalloc_pkg::ST_OK;
          head_r       <= ptr_inc(head_r);
          count_r      <= count_r - 1'b1;
          state_r      <= S_DONE;
        end
        S_SCAN: begin
          if (hit) begin
            res_status_r <= idalloc_pkg::ST_OK;
            chk_v_r      <= 1'b0;
            if (is_claim_r) begin
              state_r   <= S_COMPACT;
              wr_ptr_r  <= chk_addr_r;
              rd_ptr_r  <= ptr_inc(chk_addr_r);
              mv_left_r <= count_r - chk_idx_r - 1'b1;
              mv_v_r    <= 1'b0;
            end else begin
              state_r <= S_DONE;
            end
          end else if (rd_idx_r == count_r) begin
            chk_v_r <= 1'b0;
            state_r <= S_DONE;
          end else begin
            chk_v_r    <= 1'b1;
            chk_addr_r <= rd_ptr_r;
            chk_idx_r  <= rd_idx_r;
            rd_ptr_r   <= ptr_inc(rd_ptr_r);
            rd_idx_r   <= rd_idx_r + 1'b1;
          end
        end
        S_COMPACT: begin
          // read runs one entry ahead of the write-back
          if (mv_v_r) begin
            wr_ptr_r <= ptr_inc(wr_ptr_r);
          end
          if (mv_left_r != '0) begin
            rd_ptr_r  <= ptr_inc(rd_ptr_r);
            mv_left_r <= mv_left_r - 1'b1;
            mv_v_r    <= 1'b1;
          end else begin
            mv_v_r <= 1'b0;
            if (!mv_v_r) begin
              tail_r  <= wr_ptr_r;
              count_r <= count_r - 1'b1;
              state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = (state_r == S_DONE);
  assign res = '{
    result_id:  res_id_r,
    status:     res_status_r,
    free_count: 9'(count_r),
    high_water: 9'(fresh_r)
  };

  // ring bookkeeping: tail sits count entries past head
  assign ring_sum  = {1'b0, head_r} + (AW + 1)'(count_r);
  assign ring_tail = AW'((ring_sum >= (AW + 1)'(MAX_IDS)) ?
                         ring_sum - (AW + 1)'(MAX_IDS) : ring_sum);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_IDS))
    else $error("free list count beyond capacity");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r <= CW'(MAX_IDS))
    else $error("high-water mark beyond capacity");

  a_ring: assert property (@(posedge clk) disable iff (!rst_n)
    tail_r == ring_tail)
    else $error("head, tail and count out of step");

  a_compact_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPACT && mv_left_r == '0 && !mv_v_r) |=>
      (count_r == $past(count_r) - 1'b1))
    else $error("claim did not shorten the list");

  a_scan_ro: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> !ram_we)
    else $error("write to the free list during search");

endmodule

// ===== hw/rtl/id_allocator_fifo_free_list_core.sv =====
// Channel  Direction  Handshake           Payload
// in_      input      in_valid/in_stall   in_operation, in_target_id
// out_     output     out_valid/out_stall out_result_id, out_status,
//                                         out_free_count, out_high_water
//
// One item in work at a time. Release, clear, fresh allocate and unknown codes go straight
// to the result; allocate from the list first reads the head entry; probe and claim search
// the list, and a claim hit then compacts it. Search and compaction move one entry per
// cycle through the single read and write ports of the list memory.
// Synchronous reset empties the list and zeroes the mark; in_stall stays high during reset.
// A stalled result holds the output register; the next waits in the sequencer, in_stall high.
module id_allocator_fifo_free_list_core #(
  parameter int MAX_IDS = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_operation,
  input  logic [7:0] in_target_id,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_result_id,
  output logic [1:0] out_status,
  output logic [8:0] out_free_count,
  output logic [8:0] out_high_water
);

  localparam int AW = $clog2(MAX_IDS);

  idalloc_pkg::result_t         res;
  idalloc_pkg::result_t         out_res_r;
  logic                         res_valid;
  logic                         res_ready;
  logic                         out_valid_r;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [idalloc_pkg::ID_W-1:0] ram_wdata;
  logic [AW-1:0]                ram_raddr;
  logic [idalloc_pkg::ID_W-1:0] ram_rdata;

  // sequencer: decodes the operation, runs search and compaction
  idalloc_ctrl #(
    .MAX_IDS (MAX_IDS)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_target_id (in_target_id),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .ram_we       (ram_we),
    .ram_waddr    (ram_waddr),
    .ram_wdata    (ram_wdata),
    .ram_raddr    (ram_raddr),
    .ram_rdata    (ram_rdata)
  );

  // free list storage, kept as a ring from head to tail
  idalloc_ram #(
    .WIDTH (idalloc_pkg::ID_W),
    .DEPTH (MAX_IDS)
  ) u_list_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // output register: free when empty or when its transfer completes
  assign res_ready = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_result_id  = out_res_r.result_id;
  assign out_status     = out_res_r.status;
  assign out_free_count = out_res_r.free_count;
  assign out_high_water = out_res_r.high_water;

endmodule

// ===== tb/tb_id_allocator_fifo_free_list_core.sv =====
module tb_id_allocator_fifo_free_list_core;

  localparam int MAX_IDS      = 256;
  localparam int RANDOM_ITEMS = 1450;
  localparam int QUIET_ITEMS  = 150;     // tail of the run with no idling either side
  localparam int LONG_HOLD    = 200;     // receiver hold-off, long enough to back up the core
  localparam int DRAIN_CYCLES = 300;     // time left after the last owed result for stray transfers to show
  localparam int LIMIT        = 2000000;

  // codes the core does not define, all answered as unknown
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  // one row of the directed table; want is only used when typed is set
  typedef struct packed {
    logic [2:0]           op;
    logic [7:0]           tgt;
    bit                   typed;
    idalloc_pkg::result_t want;
  } row_t;

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic [2:0] in_operation = 3'd0;
  logic [7:0] in_target_id = 8'd0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_result_id;
  logic [1:0] out_status;
  logic [8:0] out_free_count;
  logic [8:0] out_high_water;

  id_allocator_fifo_free_list_core #(.MAX_IDS(MAX_IDS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_operation   (in_operation),
    .in_target_id   (in_target_id),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_id  (out_result_id),
    .out_status     (out_status),
    .out_free_count (out_free_count),
    .out_high_water (out_high_water)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Allocator shadow: ordered spare list plus high-water mark
  // ---------------------------------------------------------------------------
  logic [7:0] spare_ids [MAX_IDS];
  int         spare_cnt  = 0;
  int         fresh_mark = 0;

  idalloc_pkg::result_t awaited [$];     // results still owed by the core, oldest first
  row_t                 directed [$];

  int  errors         = 0;
  int  items_sent     = 0;
  int  results_seen   = 0;
  int  full_rejects   = 0;
  int  exhausted      = 0;
  bit  tx_idle_on     = 1'b1;
  bit  rx_idle_on     = 1'b1;
  bit  long_hold_due  = 1'b0;

  // close the gap left at pos, keeping the order of the rest
  function automatic void spare_remove(input int pos);
    for (int i = pos; i + 1 < spare_cnt; i++) spare_ids[i] = spare_ids[i + 1];
    spare_cnt--;
  endfunction

  // apply one operation to the shadow and return what the core must report
  function automatic idalloc_pkg::result_t alloc_step(input logic [2:0] op,
                                                      input logic [7:0] tgt);
    idalloc_pkg::result_t r;
    int      hit;
    int      t;
    t   = int'(tgt);
    hit = -1;
    for (int i = spare_cnt - 1; i >= 0; i--) if (spare_ids[i] == tgt) hit = i;
    r.result_id = tgt;
    r.status    = idalloc_pkg::ST_MISS;
    case (op)
      idalloc_pkg::OP_ALLOCATE: begin
        r.result_id = 8'd0;
        if (spare_cnt > 0) begin
          r.result_id = spare_ids[0];
          spare_remove(0);
          r.status = idalloc_pkg::ST_OK;
        end else if (fresh_mark < MAX_IDS) begin
          r.result_id = 8'(fresh_mark);
          fresh_mark++;
          r.status = idalloc_pkg::ST_OK;
        end else begin
          exhausted++;
        end
      end
      idalloc_pkg::OP_RELEASE: begin
        if (t >= fresh_mark) begin
          r.status = idalloc_pkg::ST_MISS;
        end else if (t + 1 == fresh_mark) begin
          // top id only lowers the mark; stale list entries stay put
          fresh_mark--;
          r.status = idalloc_pkg::ST_OK;
        end else if (spare_cnt >= MAX_IDS) begin
          r.status = idalloc_pkg::ST_FULL;
          full_rejects++;
        end else begin
          spare_ids[spare_cnt] = tgt;
          spare_cnt++;
          r.status = idalloc_pkg::ST_OK;
        end
      end
      idalloc_pkg::OP_CLAIM: begin
        if (hit >= 0) begin
          spare_remove(hit);
          r.status = idalloc_pkg::ST_OK;
        end
      end
      idalloc_pkg::OP_PROBE: if (hit >= 0) r.status = idalloc_pkg::ST_OK;
      idalloc_pkg::OP_CLEAR: begin
        spare_cnt  = 0;
        fresh_mark = 0;
        r.status   = idalloc_pkg::ST_OK;
      end
      default: r.status = idalloc_pkg::ST_MISS;
    endcase
    r.free_count = 9'(spare_cnt);
    r.high_water = 9'(fresh_mark);
    return r;
  endfunction

  // an id that release accepts, mostly
  function automatic logic [7:0] below_mark();
    return (fresh_mark == 0) ? 8'($urandom_range(0, 255))
                             : 8'($urandom_range(0, fresh_mark - 1));
  endfunction

  // an id currently on the spare list, or any id if the list is empty
  function automatic logic [7:0] listed_id();
    return (spare_cnt == 0) ? 8'($urandom_range(0, 255))
                            : spare_ids[$urandom_range(0, spare_cnt - 1)];
  endfunction

  task automatic flag(input string msg);
    errors++;
    $display("MISMATCH: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [8:0] got, input logic [8:0] want);
    if (got !== want)
      flag($sformatf("result %0d %s got %0d want %0d", results_seen, name, got, want));
  endtask

  task automatic add_row(input logic [2:0] op, input logic [7:0] tgt, input bit typed,
                         input logic [7:0] rid, input logic [1:0] st,
                         input logic [8:0] fc, input logic [8:0] hw);
    row_t r;
    r.op              = op;
    r.tgt             = tgt;
    r.typed           = typed;
    r.want.result_id  = rid;
    r.want.status     = st;
    r.want.free_count = fc;
    r.want.high_water = hw;
    directed = {directed, r};
  endtask

  // Offer one item, optionally after an idle burst, and hold it until the
  // transfer. The shadow is stepped at the transfer edge, so every earlier
  // item is already accounted for when the caller picks the next one.
  task automatic send_item(input logic [2:0] op, input logic [7:0] tgt,
                           input bit typed = 1'b0,
                           input idalloc_pkg::result_t want = '0);
    idalloc_pkg::result_t got;
    int      gap;
    if (tx_idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_target_id <= tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    got = alloc_step(op, tgt);
    awaited = {awaited, (typed ? want : got)};
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_side
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (rx_idle_on && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer out against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_out
    idalloc_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (awaited.size() == 0) begin
        flag($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = awaited.pop_front();
        check_field("result_id",  9'(out_result_id), 9'(want.result_id));
        check_field("status",     9'(out_status),    9'(want.status));
        check_field("free_count", out_free_count,    want.free_count);
        check_field("high_water", out_high_water,    want.high_water);
      end
    end
  end

  // hard stop if the core hangs
  initial begin : watchdog
    int cyc;
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cyc, awaited.size());
    $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    int         kind;
    int         burst;
    int         n_directed;
    int         stop_at;
    logic [2:0] op;

    // Directed table. Typed rows can be worked out by hand: fresh ids
    // after reset, rejects at or above the mark, and everything straight after clear.
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h00, 1'b1, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd1);
    add_row(idalloc_pkg::OP_ALLOCATE, 8'hFF, 1'b1, 8'd1, idalloc_pkg::ST_OK, 9'd0, 9'd2);
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h5A, 1'b1, 8'd2, idalloc_pkg::ST_OK, 9'd0, 9'd3);
    add_row(idalloc_pkg::OP_RELEASE,  8'h03, 1'b1, 8'd3,   idalloc_pkg::ST_MISS,
            9'd0, 9'd3);                                    // exactly at the mark
    add_row(idalloc_pkg::OP_RELEASE,  8'hFF, 1'b1, 8'd255, idalloc_pkg::ST_MISS,
            9'd0, 9'd3);
    add_row(idalloc_pkg::OP_RELEASE,  8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // appended
    add_row(idalloc_pkg::OP_RELEASE,  8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // double release
    add_row(idalloc_pkg::OP_PROBE,    8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_PROBE,    8'h01, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // miss
    add_row(idalloc_pkg::OP_CLAIM,    8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // takes one copy only
    add_row(idalloc_pkg::OP_PROBE,    8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_RELEASE,  8'h01, 1'b0, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_RELEASE,  8'h02, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // top id, mark drops
    add_row(idalloc_pkg::OP_RELEASE,  8'h01, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // top again, 1 left stale
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // stale id handed out
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h00, 1'b0, 8'd0, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_CLAIM,    8'hFF, 1'b0, 8'd0, idalloc_pkg::ST_OK,
            9'd0, 9'd0);                                    // miss
    add_row(idalloc_pkg::OP_CLEAR,    8'hA5, 1'b1, 8'hA5, idalloc_pkg::ST_OK, 9'd0, 9'd0);
    add_row(OP_RSVD5,                 8'hFF, 1'b1, 8'hFF, idalloc_pkg::ST_MISS, 9'd0, 9'd0);
    add_row(OP_RSVD6,                 8'h00, 1'b1, 8'h00, idalloc_pkg::ST_MISS, 9'd0, 9'd0);
    add_row(OP_RSVD7,                 8'h5A, 1'b1, 8'h5A, idalloc_pkg::ST_MISS, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_PROBE,    8'h00, 1'b1, 8'h00, idalloc_pkg::ST_MISS, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_RELEASE,  8'h00, 1'b1, 8'h00, idalloc_pkg::ST_MISS, 9'd0, 9'd0);
    add_row(idalloc_pkg::OP_ALLOCATE, 8'h7E, 1'b1, 8'd0,  idalloc_pkg::ST_OK,   9'd0, 9'd1);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_item(directed[i].op, directed[i].tgt,
                                    directed[i].typed, directed[i].want);
    n_directed = items_sent;
    stop_at    = n_directed + RANDOM_ITEMS;

    // Fill to the brim: hand out every id, try once more (exhausted), then
    // release non-top ids until the list is full, one more (list full), then
    // drop the top id and poke around a full list.
    send_item(idalloc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    repeat (MAX_IDS + 1) send_item(idalloc_pkg::OP_ALLOCATE, 8'($urandom_range(0, 255)));
    while (spare_cnt < MAX_IDS)
      send_item(idalloc_pkg::OP_RELEASE, 8'($urandom_range(0, fresh_mark - 2)));
    send_item(idalloc_pkg::OP_RELEASE, 8'($urandom_range(0, fresh_mark - 2)));
    send_item(idalloc_pkg::OP_RELEASE, 8'(fresh_mark - 1));
    repeat (3) send_item(idalloc_pkg::OP_PROBE, listed_id());
    repeat (3) send_item(idalloc_pkg::OP_CLAIM, listed_id());
    send_item(idalloc_pkg::OP_RELEASE, 8'($urandom_range(0, fresh_mark - 2)));
    send_item(idalloc_pkg::OP_ALLOCATE, 8'($urandom_range(0, 255)));

    // back to short lists, and back the core up once while the sender keeps going
    send_item(idalloc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
    long_hold_due = 1'b1;

    // Mixed bursts of mostly well-formed traffic, some noise mixed in
    while (items_sent < stop_at) begin
      tx_idle_on = (items_sent < stop_at - QUIET_ITEMS);
      rx_idle_on = tx_idle_on;
      kind  = $urandom_range(0, 19);
      burst = $urandom_range(1, 6);
      if (kind <= 5) begin
        repeat (burst) send_item(idalloc_pkg::OP_ALLOCATE, 8'($urandom_range(0, 255)));
      end else if (kind <= 10) begin
        repeat (burst)
          send_item(idalloc_pkg::OP_RELEASE,
                    ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : below_mark());
      end else if (kind <= 13) begin
        repeat (burst)
          send_item(idalloc_pkg::OP_CLAIM,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : listed_id());
      end else if (kind <= 16) begin
        repeat (burst)
          send_item(idalloc_pkg::OP_PROBE,
                    ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : listed_id());
      end else if (kind <= 18) begin
        repeat (burst) begin
          op = 3'($urandom_range(0, 7));
          send_item(op, 8'($urandom_range(0, 255)));
        end
      end else begin
        send_item(idalloc_pkg::OP_CLEAR, 8'($urandom_range(0, 255)));
      end
    end
    in_valid <= 1'b0;

    // wait for every owed result, then give stray transfers time to show
    while (awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (awaited.size() != 0) flag($sformatf("%0d results never arrived", awaited.size()));

    $display("sent %0d operations (%0d from the table), checked %0d results, %0d mismatches",
             items_sent, n_directed, results_seen, errors);
    $display("list-full rejects %0d, allocates with no id left %0d", full_rejects, exhausted);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/idalloc_pkg.sv
hw/rtl/idalloc_ram.sv
hw/rtl/idalloc_ctrl.sv
hw/rtl/id_allocator_fifo_free_list_core.sv
tb/tb_id_allocator_fifo_free_list_core.sv
